// ----- src/pwts_pkg.sv -----
// Shared types, widths and constants of the world-to-screen projection pipeline.
`default_nettype none
package pwts_pkg;

   localparam int WORLD_W   = 24;   // Q16.8 input coordinate
   localparam int COEF_W    = 16;   // Q4.12 matrix coefficient
   localparam int OUT_W     = 20;   // Q15.4 screen coordinate
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int SIZE_W    = 15;
   localparam int PROD_W    = 40;   // coordinate * coefficient
   localparam int CLIP_W    = 42;   // clip x, y, w
   localparam int SUM_W     = 43;   // cx + cw, cw - cy
   localparam int SIZE8_W   = 18;   // viewport size * 8
   localparam int LO_W      = 21;   // low slice of a split multiply
   localparam int HI_W      = 22;   // high slice of a split multiply
   localparam int PLO_W     = 39;
   localparam int PHI_W     = 41;
   localparam int NUM_W     = 62;   // signed numerator
   localparam int MAG_W     = 61;   // numerator magnitude
   localparam int DEN_W     = 42;   // |cw|
   localparam int DSR_W     = 43;   // 2*|cw|
   localparam int REM_W     = 64;   // divider remainder
   localparam int QUO_W     = 21;   // quotient bits kept
   localparam int DIV_STEPS = 21;

   localparam logic [OUT_W-1:0] OUT_MAX    = 20'h7FFFF;
   localparam logic [OUT_W-1:0] OUT_MIN    = 20'h80000;
   localparam logic [OUT_W-1:0] BEHIND_VAL = 20'hFFFF0;   // -1.0 in Q15.4
   localparam logic [QUO_W-1:0] NEG_LIMIT  = 21'd524288;
   localparam logic [QUO_W-1:0] POS_LIMIT  = 21'd524287;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_X  = 3'd0,
      CSR_ROW_Y  = 3'd1,
      CSR_ROW_W  = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4,
      CSR_CHECK  = 3'd5
   } csr_idx_type;

   // result decided before the divider (behind camera or zero w)
   typedef struct packed {
      logic             special;
      logic             behind;
      logic [OUT_W-1:0] sx;
      logic [OUT_W-1:0] sy;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem_x;
      logic [REM_W-1:0] rem_y;
      logic [DSR_W-1:0] dsr;
      logic [QUO_W-1:0] q_x;
      logic [QUO_W-1:0] q_y;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      side_type         side;
   } div_type;

   // {clamp, value}: signed, saturated quotient
   function automatic logic [OUT_W:0] sat_quo(input logic [QUO_W-1:0] q,
                                              input logic neg, input logic ovf);
      logic [QUO_W-1:0] nq;
      logic [OUT_W:0]   r;
      nq = QUO_W'(0) - q;
      if (neg) begin
         if (ovf || q > NEG_LIMIT) r = {1'b1, OUT_MIN};
         else r = {1'b0, nq[OUT_W-1:0]};
      end else begin
         if (ovf || q > POS_LIMIT) r = {1'b1, OUT_MAX};
         else r = {1'b0, q[OUT_W-1:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/perspective_world_to_screen.sv -----
// Top level: pipelined perspective projection of world points to screen pixels.
`default_nettype none
// One point enters per clock while req_ready is high. Eight stages form clip x, y
// and w and prepare the division (coordinate products, sums, viewport-scaled
// numerators split into two partial products, magnitudes, rounding offset, overflow
// check), then a 21-stage restoring divider resolves one quotient bit per stage for
// both axes, and a final stage applies the sign, saturates, substitutes the special
// cases and registers the result. A skid register behind the output keeps the
// pipeline flowing while a result waits; req_ready drops only when the skid register
// is full. Configuration writes take effect at once and must be made while the pipeline is empty.
module perspective_world_to_screen #(
   parameter int WORLD_FRAC_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [pwts_pkg::WORLD_W-1:0] req_world_x,
   input  wire logic signed [pwts_pkg::WORLD_W-1:0] req_world_y,
   input  wire logic signed [pwts_pkg::WORLD_W-1:0] req_world_z,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [pwts_pkg::OUT_W-1:0]       rsp_screen_x,
   output logic signed [pwts_pkg::OUT_W-1:0]       rsp_screen_y,
   output logic                                    rsp_behind_camera,
   output logic                                    rsp_clamped,
   input  wire logic                               csr_we,
   input  wire logic [pwts_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  wire logic [pwts_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int NPROD = 9;

   // configuration
   logic [pwts_pkg::CSR_W-1:0]  row_x_ff, row_y_ff, row_w_ff;
   logic [pwts_pkg::SIZE_W-1:0] width_ff, height_ff;
   logic                        check_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff  <= '0;
         row_y_ff  <= '0;
         row_w_ff  <= '0;
         width_ff  <= pwts_pkg::SIZE_W'(1920);
         height_ff <= pwts_pkg::SIZE_W'(1080);
         check_ff  <= 1'b0;
      end else if (csr_we) begin
         case (pwts_pkg::csr_idx_type'(csr_addr))
            pwts_pkg::CSR_ROW_X:  row_x_ff  <= csr_wdata;
            pwts_pkg::CSR_ROW_Y:  row_y_ff  <= csr_wdata;
            pwts_pkg::CSR_ROW_W:  row_w_ff  <= csr_wdata;
            pwts_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[pwts_pkg::SIZE_W-1:0];
            pwts_pkg::CSR_HEIGHT: height_ff <= csr_wdata[pwts_pkg::SIZE_W-1:0];
            pwts_pkg::CSR_CHECK:  check_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [pwts_pkg::SIZE8_W-1:0] w8, h8;
   assign w8 = {width_ff, 3'b000};
   assign h8 = {height_ff, 3'b000};

   // pipeline control
   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic [0:pwts_pkg::DIV_STEPS] dv_ff;
   logic skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
         dv_ff <= '0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         dv_ff <= {v7_ff, dv_ff[0:pwts_pkg::DIV_STEPS-1]};
      end
   end

   // stage 1: coordinate * coefficient products
   logic signed [pwts_pkg::PROD_W-1:0] p_ff [NPROD];
   logic signed [pwts_pkg::COEF_W-1:0] coef [NPROD];
   logic signed [pwts_pkg::WORLD_W-1:0] crd [NPROD];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         crd[3*r]   = req_world_x;
         crd[3*r+1] = req_world_y;
         crd[3*r+2] = req_world_z;
      end
      coef[0] = $signed(row_x_ff[15:0]);
      coef[1] = $signed(row_x_ff[31:16]);
      coef[2] = $signed(row_x_ff[47:32]);
      coef[3] = $signed(row_y_ff[15:0]);
      coef[4] = $signed(row_y_ff[31:16]);
      coef[5] = $signed(row_y_ff[47:32]);
      coef[6] = $signed(row_w_ff[15:0]);
      coef[7] = $signed(row_w_ff[31:16]);
      coef[8] = $signed(row_w_ff[47:32]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NPROD; i++) p_ff[i] <= crd[i] * coef[i];
      end
   end

   // stage 2: clip coordinates
   logic signed [pwts_pkg::CLIP_W-1:0] cx_ff, cy_ff, cw2_ff;
   logic signed [pwts_pkg::CLIP_W-1:0] tx, ty, tw;

   always_comb begin
      tx = pwts_pkg::CLIP_W'($signed(row_x_ff[63:48])) <<< WORLD_FRAC_BITS;
      ty = pwts_pkg::CLIP_W'($signed(row_y_ff[63:48])) <<< WORLD_FRAC_BITS;
      tw = pwts_pkg::CLIP_W'($signed(row_w_ff[63:48])) <<< WORLD_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff  <= pwts_pkg::CLIP_W'(p_ff[0]) + pwts_pkg::CLIP_W'(p_ff[1])
                 + pwts_pkg::CLIP_W'(p_ff[2]) + tx;
         cy_ff  <= pwts_pkg::CLIP_W'(p_ff[3]) + pwts_pkg::CLIP_W'(p_ff[4])
                 + pwts_pkg::CLIP_W'(p_ff[5]) + ty;
         cw2_ff <= pwts_pkg::CLIP_W'(p_ff[6]) + pwts_pkg::CLIP_W'(p_ff[7])
                 + pwts_pkg::CLIP_W'(p_ff[8]) + tw;
      end
   end

   // stage 3: numerator sums and the cases that bypass the divider
   logic signed [pwts_pkg::SUM_W-1:0]  ax_ff, ay_ff;
   logic signed [pwts_pkg::CLIP_W-1:0] cw3_ff;
   pwts_pkg::side_type side3_in, side3_ff;
   logic w_zero, w_nonpos;

   always_comb begin
      w_zero   = (cw2_ff == '0);
      w_nonpos = w_zero || cw2_ff[pwts_pkg::CLIP_W-1];
      side3_in.special = 1'b0;
      side3_in.behind  = 1'b0;
      side3_in.sx      = pwts_pkg::OUT_W'(w8);
      side3_in.sy      = pwts_pkg::OUT_W'(h8);
      if (check_ff && w_nonpos) begin
         side3_in.special = 1'b1;
         side3_in.behind  = 1'b1;
         side3_in.sx      = pwts_pkg::BEHIND_VAL;
         side3_in.sy      = pwts_pkg::BEHIND_VAL;
      end else if (w_zero) begin
         // ndc is infinite by the numerator sign, or zero
         side3_in.special = 1'b1;
         if (width_ff == '0) side3_in.sx = '0;
         else if (cx_ff[pwts_pkg::CLIP_W-1]) side3_in.sx = pwts_pkg::OUT_MIN;
         else if (cx_ff != '0) side3_in.sx = pwts_pkg::OUT_MAX;
         if (height_ff == '0) side3_in.sy = '0;
         else if (cy_ff[pwts_pkg::CLIP_W-1]) side3_in.sy = pwts_pkg::OUT_MAX;
         else if (cy_ff != '0) side3_in.sy = pwts_pkg::OUT_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff    <= pwts_pkg::SUM_W'(cx_ff) + pwts_pkg::SUM_W'(cw2_ff);
         ay_ff    <= pwts_pkg::SUM_W'(cw2_ff) - pwts_pkg::SUM_W'(cy_ff);
         cw3_ff   <= cw2_ff;
         side3_ff <= side3_in;
      end
   end

   // stage 4: viewport scale as two partial products per axis
   logic        [pwts_pkg::PLO_W-1:0]  plx_ff, ply_ff;
   logic signed [pwts_pkg::PHI_W-1:0]  phx_ff, phy_ff;
   logic signed [pwts_pkg::CLIP_W-1:0] cw4_ff;
   pwts_pkg::side_type side4_ff;
   logic signed [pwts_pkg::SIZE8_W:0] w8s, h8s;

   assign w8s = $signed({1'b0, w8});
   assign h8s = $signed({1'b0, h8});

   always_ff @(posedge clock) begin
      if (en) begin
         plx_ff   <= w8 * ax_ff[pwts_pkg::LO_W-1:0];
         ply_ff   <= h8 * ay_ff[pwts_pkg::LO_W-1:0];
         phx_ff   <= w8s * $signed(ax_ff[pwts_pkg::SUM_W-1:pwts_pkg::LO_W]);
         phy_ff   <= h8s * $signed(ay_ff[pwts_pkg::SUM_W-1:pwts_pkg::LO_W]);
         cw4_ff   <= cw3_ff;
         side4_ff <= side3_ff;
      end
   end

   // stage 5: full numerators
   logic signed [pwts_pkg::NUM_W-1:0]  nx_ff, ny_ff;
   logic signed [pwts_pkg::CLIP_W-1:0] cw5_ff;
   pwts_pkg::side_type side5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff    <= (pwts_pkg::NUM_W'(phx_ff) <<< pwts_pkg::LO_W)
                   + $signed({{(pwts_pkg::NUM_W-pwts_pkg::PLO_W){1'b0}}, plx_ff});
         ny_ff    <= (pwts_pkg::NUM_W'(phy_ff) <<< pwts_pkg::LO_W)
                   + $signed({{(pwts_pkg::NUM_W-pwts_pkg::PLO_W){1'b0}}, ply_ff});
         cw5_ff   <= cw4_ff;
         side5_ff <= side4_ff;
      end
   end

   // stage 6: magnitudes and quotient signs
   logic [pwts_pkg::MAG_W-1:0] anx_ff, any_ff;
   logic [pwts_pkg::DEN_W-1:0] ad6_ff;
   logic neg6x_ff, neg6y_ff;
   pwts_pkg::side_type side6_ff;
   logic [pwts_pkg::NUM_W-1:0]  nxa, nya;
   logic [pwts_pkg::CLIP_W-1:0] cwa;
   logic cw_neg;

   always_comb begin
      cw_neg = cw5_ff[pwts_pkg::CLIP_W-1];
      nxa = nx_ff[pwts_pkg::NUM_W-1] ? pwts_pkg::NUM_W'(-nx_ff) : pwts_pkg::NUM_W'(nx_ff);
      nya = ny_ff[pwts_pkg::NUM_W-1] ? pwts_pkg::NUM_W'(-ny_ff) : pwts_pkg::NUM_W'(ny_ff);
      cwa = cw_neg ? pwts_pkg::CLIP_W'(-cw5_ff) : pwts_pkg::CLIP_W'(cw5_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         anx_ff    <= nxa[pwts_pkg::MAG_W-1:0];
         any_ff    <= nya[pwts_pkg::MAG_W-1:0];
         ad6_ff    <= cwa;
         neg6x_ff  <= nx_ff[pwts_pkg::NUM_W-1] != cw_neg;
         neg6y_ff  <= ny_ff[pwts_pkg::NUM_W-1] != cw_neg;
         side6_ff  <= side5_ff;
      end
   end

   // stage 7: rounding offset, q = (2|n| + |d|) / (2|d|)
   logic [pwts_pkg::REM_W-1:0] rx7_ff, ry7_ff;
   logic [pwts_pkg::DSR_W-1:0] d7_ff;
   logic neg7x_ff, neg7y_ff;
   pwts_pkg::side_type side7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rx7_ff   <= pwts_pkg::REM_W'({anx_ff, 1'b0}) + pwts_pkg::REM_W'(ad6_ff);
         ry7_ff   <= pwts_pkg::REM_W'({any_ff, 1'b0}) + pwts_pkg::REM_W'(ad6_ff);
         d7_ff    <= {ad6_ff, 1'b0};
         neg7x_ff <= neg6x_ff;
         neg7y_ff <= neg6y_ff;
         side7_ff <= side6_ff;
      end
   end

   // stage 8: quotient too large for the kept bits
   pwts_pkg::div_type div_ff [0:pwts_pkg::DIV_STEPS];
   logic [pwts_pkg::REM_W-1:0] dtop;

   assign dtop = pwts_pkg::REM_W'(d7_ff) << pwts_pkg::QUO_W;

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0].rem_x <= rx7_ff;
         div_ff[0].rem_y <= ry7_ff;
         div_ff[0].dsr   <= d7_ff;
         div_ff[0].q_x   <= '0;
         div_ff[0].q_y   <= '0;
         div_ff[0].neg_x <= neg7x_ff;
         div_ff[0].neg_y <= neg7y_ff;
         div_ff[0].ovf_x <= rx7_ff >= dtop;
         div_ff[0].ovf_y <= ry7_ff >= dtop;
         div_ff[0].side  <= side7_ff;
      end
   end

   // restoring divider, one quotient bit per stage, MSB first
   for (genvar j = 0; j < pwts_pkg::DIV_STEPS; j++) begin : g_div
      localparam int BIT = pwts_pkg::DIV_STEPS - 1 - j;
      pwts_pkg::div_type div_in;
      logic [pwts_pkg::REM_W-1:0] shd;

      always_comb begin
         shd    = pwts_pkg::REM_W'(div_ff[j].dsr) << BIT;
         div_in = div_ff[j];
         if (div_ff[j].rem_x >= shd) begin
            div_in.rem_x    = div_ff[j].rem_x - shd;
            div_in.q_x[BIT] = 1'b1;
         end
         if (div_ff[j].rem_y >= shd) begin
            div_in.rem_y    = div_ff[j].rem_y - shd;
            div_in.q_y[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) div_ff[j+1] <= div_in;
      end
   end

   // output stage: sign, saturation, special cases
   pwts_pkg::div_type dl;
   logic [pwts_pkg::OUT_W:0] resx, resy;
   logic [pwts_pkg::OUT_W-1:0] fin_x, fin_y;
   logic fin_behind, fin_clamp, fin_v;

   always_comb begin
      dl    = div_ff[pwts_pkg::DIV_STEPS];
      fin_v = dv_ff[pwts_pkg::DIV_STEPS];
      resx  = pwts_pkg::sat_quo(dl.q_x, dl.neg_x, dl.ovf_x);
      resy  = pwts_pkg::sat_quo(dl.q_y, dl.neg_y, dl.ovf_y);
      fin_behind = dl.side.behind;
      if (dl.side.special) begin
         fin_x     = dl.side.sx;
         fin_y     = dl.side.sy;
         fin_clamp = !dl.side.behind;
      end else begin
         fin_x     = resx[pwts_pkg::OUT_W-1:0];
         fin_y     = resy[pwts_pkg::OUT_W-1:0];
         fin_clamp = resx[pwts_pkg::OUT_W] | resy[pwts_pkg::OUT_W];
      end
   end

   // output register with skid
   logic rsp_valid_ff, out_load;
   logic [pwts_pkg::OUT_W-1:0] out_x_ff, out_y_ff, sk_x_ff, sk_y_ff;
   logic out_behind_ff, out_clamp_ff, sk_behind_ff, sk_clamp_ff;

   assign out_load = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= skid_v_ff || fin_v;
         skid_v_ff    <= 1'b0;
      end else if (en && fin_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (skid_v_ff) begin
            out_x_ff      <= sk_x_ff;
            out_y_ff      <= sk_y_ff;
            out_behind_ff <= sk_behind_ff;
            out_clamp_ff  <= sk_clamp_ff;
         end else begin
            out_x_ff      <= fin_x;
            out_y_ff      <= fin_y;
            out_behind_ff <= fin_behind;
            out_clamp_ff  <= fin_clamp;
         end
      end else if (en && fin_v) begin
         sk_x_ff      <= fin_x;
         sk_y_ff      <= fin_y;
         sk_behind_ff <= fin_behind;
         sk_clamp_ff  <= fin_clamp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_screen_x      = $signed(out_x_ff);
   assign rsp_screen_y      = $signed(out_y_ff);
   assign rsp_behind_camera = out_behind_ff;
   assign rsp_clamped       = out_clamp_ff;

`ifndef SYNTH
   // skid holds data only behind an occupied output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff)
      else $error("skid full with output empty");

   // a finished result arriving at a stalled output lands in the skid
   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && !skid_v_ff && fin_v) |=> skid_v_ff)
      else $error("result dropped at stalled output");

   // behind-camera results carry fixed coordinates and no clamp
   a_behind_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_behind_camera) |->
         (!rsp_clamped && out_x_ff == pwts_pkg::BEHIND_VAL
          && out_y_ff == pwts_pkg::BEHIND_VAL))
      else $error("bad behind-camera result");
`endif

endmodule
`default_nettype wire
